>>> hw/rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants
// Field widths, the sequencer states and the per-cell control bundle used by
// the mean/median block and its sorting cells.
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 8;
    localparam int MEAN_W   = 24;
    localparam int MEDIAN_W = 17;

    typedef enum logic {
        S_LOAD,
        S_CALC
    } t_state;

    typedef struct packed {
        logic                       ins;
        logic                       shift;
        logic signed [SAMPLE_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> hw/rtl/mms_cell.sv
// ----------------------------------------------------------------------------
// mms_cell: one slot of the sorting chain
// Holds one sample. On insert it takes the new sample or its left neighbor's
// value to keep the row ascending; on shift it takes its right neighbor.
// ----------------------------------------------------------------------------
module mms_cell
    import mms_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_occ,
    input  logic                       i_left_occ,
    input  logic                       i_left_gt,
    input  logic signed [SAMPLE_W-1:0] i_left_val,
    input  logic signed [SAMPLE_W-1:0] i_right_val,
    output logic                       o_gt,
    output logic signed [SAMPLE_W-1:0] o_val
);

    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] n_val;

    // strictly greater: equal samples keep their place ahead of the new one
    assign o_gt  = i_occ && (r_val > i_ctl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (o_gt || (!i_occ && i_left_occ)) begin
                n_val = i_left_gt ? i_left_val : i_ctl.value;
            end
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> hw/rtl/mms_div.sv
// ----------------------------------------------------------------------------
// mms_div: signed mean divider
// Restoring division of (sum * 256) by the count, one quotient bit per cycle,
// truncated toward zero.
// ----------------------------------------------------------------------------
module mms_div
    import mms_pkg::*;
#(
    parameter int SUM_W = 22,
    parameter int CNT_W = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_num,
    input  logic        [CNT_W-1:0]  i_den,
    output logic                     o_done,
    output logic signed [MEAN_W-1:0] o_quot
);

    localparam int NW    = SUM_W + FRAC_W;
    localparam int STP_W = $clog2(NW + 1);

    logic signed [NW-1:0]    w_num;
    logic        [NW-1:0]    w_mag;
    logic        [CNT_W:0]   w_trial;
    logic        [CNT_W:0]   w_diff;
    logic                    w_ge;
    logic        [NW-1:0]    r_quo;
    logic        [CNT_W-1:0] r_rem;
    logic        [CNT_W-1:0] r_den;
    logic                    r_neg;
    logic        [STP_W-1:0] r_step;
    logic        [MEAN_W-1:0] w_q;

    assign w_num   = {i_num, {FRAC_W{1'b0}}};
    assign w_mag   = i_num[SUM_W-1] ? (~w_num + NW'(1)) : w_num;
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= STP_W'(NW);
        end else if (r_step != '0) begin
            r_step <= r_step - STP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[SUM_W-1];
        end else if (r_step != '0) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign o_done = (r_step == '0);
    assign w_q    = r_quo[MEAN_W-1:0];
    assign o_quot = r_neg ? -$signed(w_q) : $signed(w_q);

endmodule

>>> hw/rtl/mean_median_of_set.sv
// ----------------------------------------------------------------------------
// mean_median_of_set: mean and median of a set of signed samples
// Sorted insertion chain plus running sum; one result per set.
// ----------------------------------------------------------------------------
// A set of signed 16-bit samples streams in, one item per cycle, the final
// sample marked by tlast. Samples drop into a row of MAX_ITEMS sorting cells
// that keep the set ascending, while a running sum and count advance. Samples
// arriving with the row full are dropped and reported through tuser. After the
// tlast item the block stops taking input and works out the result: a restoring
// divider produces sum*256/count while the row shifts down toward cell 0 until
// the middle element(s) sit in cells 0 and 1. The result register loads when
// both finish and any earlier result has been taken, and input reopens as it
// loads, even if the result still waits to be taken. Loading runs at one item
// per clock, but input is held off while each set is evaluated. The median
// output is twice the median (sum of the two middle samples for an even count)
// so it stays exact in integers.
// ----------------------------------------------------------------------------
module mean_median_of_set
    import mms_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
    localparam int OUT_W    = MEAN_W + MEDIAN_W + CNT_W,
    localparam int DATA_W   = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream: tdata = sample_value[15:0]; tlast = last_item
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,
    input  logic              i_s_tlast,
    // output stream: tdata = mean_q8[23:0], median_x2[40:24],
    //                item_count[CNT_W+40:41], zero fill above
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    // tuser = overflow_flag
    output logic              o_m_tuser
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_ITEMS);

    // control state
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic                       r_drop, n_drop;
    logic [CNT_W-1:0]           r_shift_cnt, n_shift_cnt;

    // result register
    logic                       r_m_valid, n_m_valid;
    logic signed [MEAN_W-1:0]   r_mean;
    logic signed [MEDIAN_W-1:0] r_median;
    logic [CNT_W-1:0]           r_cnt_out;
    logic                       r_flag;
    logic                       w_load_out;

    logic                       w_accept;
    logic                       w_room;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [MEAN_W-1:0]   w_quot;
    logic signed [MEDIAN_W-1:0] w_median;
    t_cell_ctl                  w_ctl;

    logic signed [SAMPLE_W-1:0] w_val [MAX_ITEMS];
    logic                       w_gt  [MAX_ITEMS];
    logic                       w_occ [MAX_ITEMS];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_room     = (r_count < CNT_W'(MAX_ITEMS));
    assign o_s_tready = (r_state == S_LOAD);

    // ------------------------------------------------------------------
    // sorting chain
    // ------------------------------------------------------------------
    assign w_ctl.ins   = w_accept && w_room;
    assign w_ctl.shift = (r_state == S_CALC) && (r_shift_cnt != '0);
    assign w_ctl.value = $signed(i_s_tdata);

    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
        assign w_occ[gi] = (CNT_W'(gi) < r_count);

        mms_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[gi]),
            .i_left_occ  ((gi == 0) ? 1'b1 : w_occ[(gi == 0) ? 0 : gi - 1]),
            .i_left_gt   ((gi == 0) ? 1'b0 : w_gt[(gi == 0) ? 0 : gi - 1]),
            .i_left_val  (w_val[(gi == 0) ? 0 : gi - 1]),
            .i_right_val (w_val[(gi == MAX_ITEMS - 1) ? gi : gi + 1]),
            .o_gt        (w_gt[gi]),
            .o_val       (w_val[gi])
        );
    end

    // ------------------------------------------------------------------
    // mean divider, started with the totals that include the tlast item
    // ------------------------------------------------------------------
    assign w_div_start = w_accept && i_s_tlast;

    mms_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (n_sum),
        .i_den   (n_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // middle elements sit in cells 0 and 1 once the shift count runs out
    assign w_median = r_count[0]
        ? $signed({w_val[0], 1'b0})
        : (MEDIAN_W'(w_val[0]) + MEDIAN_W'(w_val[1]));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_drop      = r_drop;
        n_shift_cnt = r_shift_cnt;
        n_m_valid   = r_m_valid && !i_m_tready;
        w_load_out  = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                        n_sum   = r_sum + SUM_W'($signed(i_s_tdata));
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_shift_cnt = (n_count - CNT_W'(1)) >> 1;
                        n_state     = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (r_shift_cnt != '0) begin
                    n_shift_cnt = r_shift_cnt - CNT_W'(1);
                end else if (w_div_done && (!r_m_valid || i_m_tready)) begin
                    // hand off the result and clear the set
                    w_load_out = 1'b1;
                    n_m_valid  = 1'b1;
                    n_count    = '0;
                    n_sum      = '0;
                    n_drop     = 1'b0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sum       <= '0;
            r_drop      <= 1'b0;
            r_shift_cnt <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_drop      <= n_drop;
            r_shift_cnt <= n_shift_cnt;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_mean    <= w_quot;
            r_median  <= w_median;
            r_cnt_out <= r_count;
            r_flag    <= r_drop;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = DATA_W'({r_cnt_out, r_median, r_mean});
    assign o_m_tuser  = r_flag;

`ifndef SYNTH
    // no new item may enter while the set is being evaluated
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input taken right after the last item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("sample count above capacity");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_count == CNT_W'(MAX_ITEMS)))
        else $error("drop mark set with room left");

    a_result_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_m_valid) && r_m_valid) |-> ($past(r_state) == S_CALC))
        else $error("result raised outside evaluation");
`endif

endmodule
